### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the calibrator RTL
// Clocked property checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clk_i edge outside reset
`define SBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check on every clk_i edge, reset included
`define SBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Constants, types and helper functions of the sensor bias calibrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbc_pkg;

  // Channel layout
  localparam int CHANNELS    = 6;   // channels that take part in calibration
  localparam int NUM_SAMPLES = 6;   // sample fields on the port
  localparam int SAMPLE_BITS = 24;

  // Register and arithmetic widths
  localparam int CFG_BITS     = 23;  // widest register
  localparam int CFG_IDX_BITS = 2;
  localparam int CNT_BITS     = 11;  // stable_count, run length, divisor
  localparam int SUM_BITS     = SAMPLE_BITS + CNT_BITS;  // signed run sum
  localparam int DVD_BITS     = SUM_BITS - 1;            // sum magnitude
  localparam int QUO_BITS     = SAMPLE_BITS;             // mean magnitude
  localparam int REM_BITS     = CNT_BITS;
  localparam int STEP_W       = $clog2(QUO_BITS + 1);
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [CNT_BITS-1:0]           run_t;
  typedef logic [CH_W-1:0]               ch_t;

  localparam run_t RUN_MAX = '1;
  localparam smp_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam smp_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STABLE_COUNT = 2'd0,
    CFG_TOLERANCE    = 2'd1,
    CFG_ZERO_BAND    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DSTART,
    ST_DWAIT,
    ST_FINISH,
    ST_OUT
  } state_e;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Magnitude of a sample, unsigned (most negative value maps to 2^(N-1))
  function automatic logic [SAMPLE_BITS-1:0] smp_mag(smp_t a);
    logic [SAMPLE_BITS-1:0] u;
    u = a;
    return a[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
  endfunction

  // a - b saturated to the sample range
  function automatic smp_t sat_sub(smp_t a, smp_t b);
    logic signed [SAMPLE_BITS:0] d;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    if (d[SAMPLE_BITS] != d[SAMPLE_BITS-1]) begin
      return d[SAMPLE_BITS] ? SMP_MIN : SMP_MAX;
    end
    return d[SAMPLE_BITS-1:0];
  endfunction

endpackage

### rtl/sbc_intf.sv
// ----------------------------------------------------------------------------
// sbc_intf
// Valid/ready channels for sample items and corrected result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbc_in_if;
  import sbc_pkg::*;

  logic valid;
  logic ready;
  smp_t sample_0;
  smp_t sample_1;
  smp_t sample_2;
  smp_t sample_3;
  smp_t sample_4;
  smp_t sample_5;
  smp_t flag_in;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           flag_in,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           flag_in,
    output ready
  );
endinterface

interface sbc_out_if;
  import sbc_pkg::*;

  logic valid;
  logic ready;
  smp_t corrected_0;
  smp_t corrected_1;
  smp_t corrected_2;
  smp_t corrected_3;
  smp_t corrected_4;
  smp_t corrected_5;
  smp_t flag_out;

  modport source (
    output valid, corrected_0, corrected_1, corrected_2, corrected_3,
           corrected_4, corrected_5, flag_out,
    input  ready
  );
  modport sink (
    input  valid, corrected_0, corrected_1, corrected_2, corrected_3,
           corrected_4, corrected_5, flag_out,
    output ready
  );
endinterface

### rtl/sbc_divider.sv
// ----------------------------------------------------------------------------
// sbc_divider
// Restoring divider, one quotient bit per cycle: sum magnitude / run length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbc_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [sbc_pkg::DVD_BITS-1:0]    dividend_i,
  input  logic [sbc_pkg::CNT_BITS-1:0]    divisor_i,
  output logic [sbc_pkg::QUO_BITS-1:0]    quotient_o,
  output sbc_pkg::div_stat_t              stat_o
);
  import sbc_pkg::*;

  logic [REM_BITS-1:0] rem_q, rem_d;
  logic [QUO_BITS-1:0] quo_q, quo_d;
  logic [CNT_BITS-1:0] div_q;
  logic [STEP_W-1:0]   step_q;
  logic                busy_q;
  logic                done_q;

  logic [REM_BITS:0]   trial;
  logic [REM_BITS:0]   trial_sub;
  logic                fits;

  // One compare-subtract step; the quotient shifts in where the dividend
  // bits shift out
  always_comb begin
    trial     = {rem_q, quo_q[QUO_BITS-1]};
    trial_sub = trial - {1'b0, div_q};
    fits      = (trial >= {1'b0, div_q});
    rem_d     = fits ? trial_sub[REM_BITS-1:0] : trial[REM_BITS-1:0];
    quo_d     = {quo_q[QUO_BITS-2:0], fits};
  end

  // Control: step counter, busy and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QUO_BITS);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient is known to fit QUO_BITS, so the top dividend
  // bits seed the remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_BITS'(dividend_i[DVD_BITS-1:QUO_BITS]);
      quo_q <= dividend_i[QUO_BITS-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `SBC_ASSERT(a_rem_below_div, busy_q |-> (rem_q < div_q), "remainder reached divisor")
  `SBC_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a running division")
  `SBC_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> (!busy_q && !done_q), "divider active in reset")

endmodule

### rtl/sensor_bias_calibrator.sv
// Flow: once calibrated an item passes ST_CHECK and ST_OUT; an unstable sample
//   adds ST_FINISH; a stable sample while calibrating also runs the shared divider
//   for each channel in turn. One item at a time: a new item is accepted only in
//   ST_IDLE, and ST_OUT waits while the result register is full and not taken.
// Reset: bias, sums, previous sample and run count cleared, calibrating, stable_count
//   = 10, tolerance = zero_band = 0; a valid-index write clears the same state.
// ----------------------------------------------------------------------------
// sensor_bias_calibrator
// Per-channel offset calibration over a run of stable samples, then
// bias-corrected, saturated pass of every sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_bias_calibrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sbc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [sbc_pkg::CFG_BITS-1:0]        cfg_data_i,
  sbc_in_if.sink                              in_i,
  sbc_out_if.source                           res_o
);
  import sbc_pkg::*;

  localparam ch_t CH_LAST = CH_W'(CHANNELS - 1);

  // Registers
  state_e              state_q, state_d;
  run_t                stable_count_q;
  logic [CFG_BITS-1:0] tolerance_q;
  logic [CFG_BITS-1:0] zero_band_q;

  smp_t                smp_q  [NUM_SAMPLES];
  smp_t                flag_q;
  smp_t                prev_q [CHANNELS];
  sum_t                sum_q  [CHANNELS];
  smp_t                bias_q [CHANNELS];
  run_t                run_q;
  logic                done_q;
  ch_t                 ch_q;
  smp_t                flag_res_q;

  logic                out_valid_q;
  smp_t                corr_q [NUM_SAMPLES];
  smp_t                out_flag_q;

  // Combinational
  logic                accept;
  logic                cfg_hit;
  logic                nonzero;
  logic                close;
  logic                stable;
  run_t                run_inc;
  logic                load_out;
  logic                div_start;
  sum_t                sum_sel;
  sum_t                sum_abs;
  logic [QUO_BITS-1:0] quo;
  div_stat_t           div_stat;
  smp_t                corr_d [NUM_SAMPLES];

  assign accept = in_i.valid && in_i.ready;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    case (cfg_idx_e'(cfg_idx_i))
      CFG_STABLE_COUNT,
      CFG_TOLERANCE,
      CFG_ZERO_BAND: cfg_hit = cfg_we_i;
      default:       cfg_hit = 1'b0;
    endcase
  end

  // Stability test, all channels side by side
  always_comb begin
    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        dmag;
    nonzero = 1'b0;
    close   = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      diff = {smp_q[i][SAMPLE_BITS-1], smp_q[i]} - {prev_q[i][SAMPLE_BITS-1], prev_q[i]};
      dmag = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
      if (smp_mag(smp_q[i]) > {1'b0, zero_band_q}) nonzero = 1'b1;
      if (dmag > {2'b00, tolerance_q}) close = 1'b0;
    end
    stable  = nonzero && close;
    run_inc = (run_q != RUN_MAX) ? run_q + 1'b1 : run_q;
  end

  // Divider operands for the channel in turn
  always_comb begin
    sum_sel = sum_q[ch_q];
    sum_abs = sum_sel[SUM_BITS-1] ? -sum_sel : sum_sel;
  end

  sbc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs[DVD_BITS-1:0]),
    .divisor_i  (run_q),
    .quotient_o (quo),
    .stat_o     (div_stat)
  );

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_CHECK;
      ST_CHECK: begin
        if (done_q)      state_d = ST_OUT;
        else if (stable) state_d = ST_DSTART;
        else             state_d = ST_FINISH;
      end
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_stat.done) state_d = (ch_q == CH_LAST) ? ST_FINISH : ST_DSTART;
      end
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_i.ready = 1'b1;
      ST_DSTART: div_start  = 1'b1;
      ST_OUT:    load_out   = !out_valid_q || res_o.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_count_q <= run_t'(10);
      tolerance_q    <= '0;
      zero_band_q    <= '0;
      run_q          <= '0;
      done_q         <= 1'b0;
      ch_q           <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_q[i] <= '0;
        sum_q[i]  <= '0;
        bias_q[i] <= '0;
      end
    end else if (cfg_hit) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STABLE_COUNT: stable_count_q <= cfg_data_i[CNT_BITS-1:0];
        CFG_TOLERANCE:    tolerance_q    <= cfg_data_i;
        CFG_ZERO_BAND:    zero_band_q    <= cfg_data_i;
        default:          ;
      endcase
      run_q  <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_q[i] <= '0;
        sum_q[i]  <= '0;
        bias_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_CHECK: begin
          if (!done_q) begin
            ch_q <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
              prev_q[i] <= smp_q[i];
              if (stable) sum_q[i] <= sum_q[i] + SUM_BITS'(smp_q[i]);
              else        sum_q[i] <= '0;
            end
            run_q <= stable ? run_inc : '0;
          end
        end
        ST_DWAIT: begin
          if (div_stat.done) begin
            bias_q[ch_q] <= sum_sel[SUM_BITS-1] ? -smp_t'(quo) : smp_t'(quo);
            ch_q         <= ch_t'(ch_q + 1'b1);
          end
        end
        ST_FINISH: begin
          if (run_q >= stable_count_q) done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Item capture and flag result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q[0] <= in_i.sample_0;
      smp_q[1] <= in_i.sample_1;
      smp_q[2] <= in_i.sample_2;
      smp_q[3] <= in_i.sample_3;
      smp_q[4] <= in_i.sample_4;
      smp_q[5] <= in_i.sample_5;
      flag_q   <= in_i.flag_in;
    end
    if (state_q == ST_CHECK && done_q) begin
      flag_res_q <= flag_q;
    end else if (state_q == ST_FINISH) begin
      flag_res_q <= (run_q >= stable_count_q) ? smp_t'(1) : '0;
    end
  end

  // Correction per field; unused channels pass the sample through
  for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_corr
    if (g < CHANNELS) begin : g_used
      assign corr_d[g] = sat_sub(smp_q[g], bias_q[g]);
    end else begin : g_pass
      assign corr_d[g] = smp_q[g];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      corr_q     <= corr_d;
      out_flag_q <= flag_res_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.corrected_0 = corr_q[0];
  assign res_o.corrected_1 = corr_q[1];
  assign res_o.corrected_2 = corr_q[2];
  assign res_o.corrected_3 = corr_q[3];
  assign res_o.corrected_4 = corr_q[4];
  assign res_o.corrected_5 = corr_q[5];
  assign res_o.flag_out    = out_flag_q;

  `SBC_ASSERT(a_start_when_free, div_start |-> !div_stat.busy, "divider started while busy")
  `SBC_ASSERT(a_divisor_nonzero, div_start |-> (run_q != '0), "division by empty run")
  `SBC_ASSERT(a_res_held, (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.flag_out)), "result item dropped while stalled")

endmodule

### tb/sensor_bias_calibrator_tb.sv
// ----------------------------------------------------------------------------
// sensor_bias_calibrator_tb
// Self-checking bench for the bias calibrator. A queue-fed driver sends
// sample items with random gaps, and a behavioral model predicts each
// corrected item. A monitor with random stalls compares every result field
// by field. Directed runs cover the sample extremes, saturation, the
// zero-count and spare-index register writes, and the tolerance and zero
// band edges. Random phases then reprogram the registers and send mostly
// stable runs, with breaks and noise mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_bias_calibrator_tb;
  import sbc_pkg::*;

  localparam int          RANDOM_ITEMS = 1300;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam int          SETTLE       = 200;    // margin above the slowest item
  localparam int unsigned RUN_CAP      = 2047;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;  // no register here
  localparam longint      SMP_TOP      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint      SMP_BOT      = -SMP_TOP - 1;
  localparam logic [CFG_BITS-1:0] CFG_ALL = '1;

  // One item on either channel: six channels plus the flag field
  typedef struct packed {
    smp_t [NUM_SAMPLES-1:0] ch;
    smp_t                   flag;
  } frame_t;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b1;
  logic                    cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i  = '0;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;

  sbc_in_if  smp_if ();
  sbc_out_if res_if ();

  sensor_bias_calibrator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (smp_if),
    .res_o      (res_if)
  );

  always #6 clk_i = ~clk_i;

  // Calibration model state and register copies
  longint      cal_bias [NUM_SAMPLES];
  longint      cal_sum  [NUM_SAMPLES];
  longint      cal_prev [NUM_SAMPLES];
  int unsigned cal_run    = 0;
  bit          cal_frozen = 1'b0;
  longint      need_count = 10;
  longint      max_step   = 0;
  longint      dead_band  = 0;

  frame_t      pending_frames [$];
  frame_t      expected_out   [$];
  frame_t      on_wire;
  bit          feed_busy;
  int unsigned feed_wait;
  int unsigned take_wait;
  bit          no_gaps    = 1'b0;
  int          mismatches = 0;
  int          cycle_count = 0;

  function automatic longint abs64(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic smp_t sat24(longint x);
    if (x > SMP_TOP) x = SMP_TOP;
    if (x < SMP_BOT) x = SMP_BOT;
    return x[SAMPLE_BITS-1:0];
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 9);
  endfunction

  // Advance the calibration model by one sample item, return the result item
  function automatic frame_t correct_frame(frame_t f);
    longint s [NUM_SAMPLES];
    bit     nonzero;
    bit     close;
    frame_t r;
    nonzero = 1'b0;
    close   = 1'b1;
    for (int i = 0; i < NUM_SAMPLES; i++) s[i] = $signed(f.ch[i]);
    r.flag = f.flag;
    if (!cal_frozen) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (abs64(s[i]) > dead_band) nonzero = 1'b1;
        if (abs64(s[i] - cal_prev[i]) > max_step) close = 1'b0;
      end
      if (nonzero && close) begin
        if (cal_run < RUN_CAP) cal_run++;
        for (int i = 0; i < CHANNELS; i++) begin
          cal_sum[i]  += s[i];
          cal_bias[i] = cal_sum[i] / longint'(cal_run);  // truncates toward zero
        end
      end else begin
        cal_run = 0;
        for (int i = 0; i < CHANNELS; i++) cal_sum[i] = 0;
      end
      for (int i = 0; i < CHANNELS; i++) cal_prev[i] = s[i];
      r.flag = '0;
      if (longint'(cal_run) >= need_count) begin
        r.flag     = smp_t'(1);
        cal_frozen = 1'b1;
      end
    end
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      r.ch[i] = (i < CHANNELS) ? sat24(s[i] - cal_bias[i]) : f.ch[i];
    end
    return r;
  endfunction

  // Full-range word with the extremes weighted up
  function automatic smp_t any_word();
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      default: return smp_t'($urandom());
    endcase
  endfunction

  function automatic longint near_step(longint tol);
    if (tol == 0) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? tol : -tol;
    return longint'($urandom_range(0, int'(2 * tol))) - tol;
  endfunction

  // Next sample: mostly within tolerance of the last one, else a step just
  // past tolerance, a frame around the zero band, or full-range noise
  function automatic frame_t make_frame(frame_t prev, longint tol, longint zb, bit fresh);
    frame_t      f;
    longint      v;
    int unsigned kind;
    int unsigned pick;
    kind = fresh ? 17 : $urandom_range(0, 19);
    pick = $urandom_range(0, NUM_SAMPLES - 1);
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      v = $signed(prev.ch[i]);
      if (kind == 15 && i == pick) begin
        v += $urandom_range(0, 1) ? tol + 1 : -(tol + 1);
      end else if (kind <= 15) begin
        v += near_step(tol);
      end else if (kind == 16) begin
        v = longint'($urandom_range(0, int'(2 * zb))) - zb;
        if (i == pick && $urandom_range(0, 1) == 1) begin
          v = $urandom_range(0, 1) ? zb + 1 : -(zb + 1);
        end else if ($urandom_range(0, 3) == 0) begin
          v = $urandom_range(0, 1) ? zb : -zb;
        end
      end else begin
        v = $signed(any_word());
      end
      f.ch[i] = sat24(v);
    end
    f.flag = any_word();
    return f;
  endfunction

  function automatic frame_t pack_frame(longint a, longint b, longint c, longint d,
                                        longint e, longint g, smp_t flag);
    frame_t f;
    f.ch[0] = sat24(a);
    f.ch[1] = sat24(b);
    f.ch[2] = sat24(c);
    f.ch[3] = sat24(d);
    f.ch[4] = sat24(e);
    f.ch[5] = sat24(g);
    f.flag  = flag;
    return f;
  endfunction

  // Register write; the model follows at the same edge. Caller lowers cfg_we_i.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_STABLE_COUNT || idx == CFG_TOLERANCE || idx == CFG_ZERO_BAND) begin
      case (idx)
        CFG_STABLE_COUNT: need_count = longint'(data[CNT_BITS-1:0]);
        CFG_TOLERANCE:    max_step   = longint'(data);
        default:          dead_band  = longint'(data);
      endcase
      // a write to any of the three registers restarts calibration
      for (int i = 0; i < NUM_SAMPLES; i++) begin
        cal_bias[i] = 0;
        cal_sum[i]  = 0;
        cal_prev[i] = 0;
      end
      cal_run    = 0;
      cal_frozen = 1'b0;
    end
  endtask

  // Wait until every queued item is sent and every result has come back
  task automatic drain();
    while (pending_frames.size() != 0 || feed_busy || expected_out.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_if.valid    <= 1'b0;
      smp_if.sample_0 <= '0;
      smp_if.sample_1 <= '0;
      smp_if.sample_2 <= '0;
      smp_if.sample_3 <= '0;
      smp_if.sample_4 <= '0;
      smp_if.sample_5 <= '0;
      smp_if.flag_in  <= '0;
      feed_busy = 1'b0;
      feed_wait = draw_gap();
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        expected_out.push_back(correct_frame(on_wire));
        feed_busy = 1'b0;
      end
      if (!feed_busy && pending_frames.size() != 0) begin
        if (feed_wait == 0) begin
          on_wire   = pending_frames.pop_front();
          feed_busy = 1'b1;
          feed_wait = draw_gap();
          smp_if.sample_0 <= on_wire.ch[0];
          smp_if.sample_1 <= on_wire.ch[1];
          smp_if.sample_2 <= on_wire.ch[2];
          smp_if.sample_3 <= on_wire.ch[3];
          smp_if.sample_4 <= on_wire.ch[4];
          smp_if.sample_5 <= on_wire.ch[5];
          smp_if.flag_in  <= on_wire.flag;
        end else begin
          feed_wait--;
        end
      end
      smp_if.valid <= feed_busy;
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    frame_t got;
    frame_t want;
    bit     take_ready;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      take_wait = draw_gap();
    end else begin
      take_ready = res_if.ready;
      if (res_if.valid && res_if.ready) begin
        got.ch[0] = res_if.corrected_0;
        got.ch[1] = res_if.corrected_1;
        got.ch[2] = res_if.corrected_2;
        got.ch[3] = res_if.corrected_3;
        got.ch[4] = res_if.corrected_4;
        got.ch[5] = res_if.corrected_5;
        got.flag  = res_if.flag_out;
        if (expected_out.size() == 0) begin
          $display("%0t: result item with none expected: corrected_0 %0d flag_out %0d",
                   $time, $signed(got.ch[0]), $signed(got.flag));
          mismatches++;
        end else begin
          want = expected_out.pop_front();
          for (int i = 0; i < NUM_SAMPLES; i++) begin
            if (got.ch[i] !== want.ch[i]) begin
              $display("%0t: corrected_%0d expected %0d, got %0d",
                       $time, i, $signed(want.ch[i]), $signed(got.ch[i]));
              mismatches++;
            end
          end
          if (got.flag !== want.flag) begin
            $display("%0t: flag_out expected %0d, got %0d",
                     $time, $signed(want.flag), $signed(got.flag));
            mismatches++;
          end
        end
        take_wait  = draw_gap();
        take_ready = (take_wait == 0);
      end else if (!res_if.ready) begin
        if (take_wait > 0) take_wait--;
        take_ready = (take_wait == 0);
      end
      res_if.ready <= take_ready;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    frame_t              f;
    frame_t              last;
    frame_t              ext;
    int                  fed_total;
    int                  n;
    logic [CFG_BITS-1:0] cnt_word;
    logic [CFG_BITS-1:0] tol;
    logic [CFG_BITS-1:0] zb;
    fed_total = 0;
    last      = '0;

    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: count 10, zero tolerance, so only repeated samples are stable
    pending_frames.push_back(pack_frame(0, 0, 0, 0, 0, 0, any_word()));
    ext = pack_frame(SMP_TOP, SMP_BOT, 1, -1, 0, 12345, SMP_MAX);
    repeat (11) pending_frames.push_back(ext);
    // bias on channels 0 and 1 now sits at the extremes: corrected values saturate both ways
    pending_frames.push_back(pack_frame(SMP_BOT, SMP_BOT, SMP_BOT, SMP_BOT, SMP_BOT,
                                        SMP_BOT, SMP_MAX));
    pending_frames.push_back(pack_frame(SMP_TOP, SMP_TOP, SMP_TOP, SMP_TOP, SMP_TOP,
                                        SMP_TOP, SMP_MIN));
    drain();
    repeat (2) @(posedge clk_i);

    // Zero count: done on the first sample, which sets the bias if it is stable
    write_reg(CFG_STABLE_COUNT, '0);
    write_reg(CFG_TOLERANCE, CFG_ALL);
    write_reg(CFG_ZERO_BAND, '0);
    cfg_we_i <= 1'b0;
    f = make_frame(f, 0, 0, 1'b1);
    f.ch[0] = SMP_MAX;
    pending_frames.push_back(f);
    pending_frames.push_back(make_frame(f, 0, 0, 1'b1));
    drain();
    repeat (2) @(posedge clk_i);

    // Count 3 with junk in the upper data bits, widest zero band, tolerance edges
    write_reg(CFG_STABLE_COUNT, 23'h7FF803);
    write_reg(CFG_TOLERANCE, 23'd100);
    write_reg(CFG_ZERO_BAND, CFG_ALL);
    cfg_we_i <= 1'b0;
    pending_frames.push_back(pack_frame(5, 5, 5, 5, 5, 5, any_word()));
    pending_frames.push_back(pack_frame(SMP_BOT, -777, 333, -1, 0, 4000, any_word()));
    pending_frames.push_back(pack_frame(SMP_BOT, -877, 432, -2, 100, 3901, any_word()));
    drain();
    repeat (2) @(posedge clk_i);
    // spare index: ignored, the run carries on
    write_reg(CFG_IDX_SPARE, CFG_ALL);
    cfg_we_i <= 1'b0;
    pending_frames.push_back(pack_frame(SMP_BOT, -800, 400, -50, 50, 3950, any_word()));
    pending_frames.push_back(pack_frame(SMP_BOT, -700, 300, 50, -50, 4000, any_word()));
    pending_frames.push_back(pack_frame(SMP_BOT, -700, 300, 50, -50, 4000, any_word()));

    // Random phases, each with fresh register settings
    while (fed_total < RANDOM_ITEMS) begin
      drain();
      repeat (2) @(posedge clk_i);
      case ($urandom_range(0, 19))
        0, 1:    cnt_word = '0;
        2:       cnt_word = CFG_BITS'(RUN_CAP);
        3:       cnt_word = CFG_BITS'(1024);
        default: cnt_word = CFG_BITS'($urandom_range(1, 12));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        cnt_word[CFG_BITS-1:CNT_BITS] = 12'($urandom_range(1, 4095));
      end
      case ($urandom_range(0, 4))
        0:       tol = '0;
        1:       tol = CFG_BITS'($urandom_range(0, 255));
        2:       tol = CFG_BITS'($urandom());
        3:       tol = CFG_ALL;
        default: tol = CFG_BITS'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 4))
        0:       zb = '0;
        1:       zb = CFG_BITS'($urandom_range(0, 255));
        2:       zb = CFG_BITS'($urandom());
        3:       zb = CFG_ALL;
        default: zb = CFG_BITS'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_TOLERANCE, tol);
      write_reg(CFG_ZERO_BAND, zb);
      if ($urandom_range(0, 4) == 0) write_reg(CFG_IDX_SPARE, CFG_BITS'($urandom()));
      write_reg(CFG_STABLE_COUNT, cnt_word);
      cfg_we_i <= 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 60);
      last = make_frame(last, longint'(tol), longint'(zb), 1'b1);
      pending_frames.push_back(last);
      for (int k = 1; k < n; k++) begin
        last = make_frame(last, longint'(tol), longint'(zb), 1'b0);
        pending_frames.push_back(last);
      end
      fed_total += n;
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sbc_pkg.sv
rtl/sbc_intf.sv
rtl/sbc_divider.sv
rtl/sensor_bias_calibrator.sv
tb/sensor_bias_calibrator_tb.sv
